[sv/blpp_pkg.sv]
// Shared types and constants for the book-level pair parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package blpp_pkg;

    localparam int MAX_EXPONENT_DEF = 99;
    localparam logic [4:0] DECIMAL_SCALE_RESET = 5'd8;

    // Array-level parse phases.
    localparam logic [2:0] PH_START      = 3'd0;
    localparam logic [2:0] PH_BETWEEN    = 3'd1;
    localparam logic [2:0] PH_SEEK_PQ    = 3'd2;
    localparam logic [2:0] PH_PRICE      = 3'd3;
    localparam logic [2:0] PH_SEEK_QQ    = 3'd4;
    localparam logic [2:0] PH_QTY        = 3'd5;
    localparam logic [2:0] PH_SEEK_CLOSE = 3'd6;

    // Number grammar phases.
    localparam logic [2:0] NU_LEAD  = 3'd0;
    localparam logic [2:0] NU_INT   = 3'd1;
    localparam logic [2:0] NU_FRAC  = 3'd2;
    localparam logic [2:0] NU_ESIGN = 3'd3;
    localparam logic [2:0] NU_EXP   = 3'd4;
    localparam logic [2:0] NU_DONE  = 3'd5;

    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [5:0] DROP_CAP = 6'd63;
    localparam logic [4:0] FRAC_CAP = 5'd31;

    // Largest mantissa that still takes a digit of five or less: (2^64-1)/10.
    localparam logic [63:0] FIT_LIMIT = 64'd1844674407370955161;
    // Largest magnitude that may be multiplied by ten without leaving range.
    localparam logic [63:0] MUL_LIMIT = 64'd922337203685477580;
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } blpp_in_t;

    typedef struct packed {
        logic signed [63:0] price_value;
        logic signed [63:0] quantity_value;
        logic               saturated;
    } blpp_out_t;

    typedef struct packed {
        logic take;
        logic step;
        logic fin_price;
        logic fin_emit;
    } blpp_cmd_t;

    typedef struct packed {
        logic start_price;
        logic start_emit;
        logic done;
    } blpp_status_t;

endpackage

`default_nettype wire

[sv/book_level_pair_parser_core.sv]
// Top level of the book-level pair parser: controller plus datapath.
// Depends on blpp_pkg, blpp_ctrl and blpp_datapath.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    blpp_in_t  (text_byte, final_byte)
//   out      output     out_valid / out_ready  blpp_out_t (price, quantity, saturated)
//   cfg      input      cfg_valid / cfg_ready  decimal_scale, 5 bits
//
// Ordinary bytes are taken one per cycle. A closing price quote or a byte that completes a pair
// starts a scaling job in the shared scaler, and input is held until it ends: one multiply by
// ten per cycle, a saturating step where the next multiply would overflow, a divide by ten over
// 16 nibble steps (nibble-wide long division), and then a finishing step.
// A finished result waits in the output register while the next bytes are taken; a job
// that completes a pair waits for that register to drain. Reset leaves the parser expecting
// an opening bracket with decimal_scale at 8; configuration is always ready.
`default_nettype none

module book_level_pair_parser_core
    import blpp_pkg::*;
#(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire blpp_in_t   in_item,
    output logic            out_valid,
    input  wire logic       out_ready,
    output blpp_out_t       out_item,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [4:0] cfg_data
);

    blpp_cmd_t    cmd;
    blpp_status_t status;

    assign cfg_ready = 1'b1;

    blpp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    blpp_datapath #(
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

[sv/blpp_ctrl.sv]
// Controller for the pair parser: input and output handshakes, scaling jobs.
// Depends on blpp_pkg for command and status structs.
`default_nettype none

module blpp_ctrl
    import blpp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    input  wire blpp_status_t status,
    output blpp_cmd_t         cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_SCALE = 1'b1;

    logic state_reg, state_next;
    logic job_emit_reg, job_emit_next;
    logic out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next    = state_reg;
        job_emit_next = job_emit_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.start_price || status.start_emit)
                    begin
                        state_next    = ST_SCALE;
                        job_emit_next = status.start_emit;
                    end
                end
            end
            ST_SCALE:
            begin
                if (!status.done)
                begin
                    cmd.step = 1'b1;
                end
                else if (!job_emit_reg)
                begin
                    cmd.fin_price = 1'b1;
                    state_next    = ST_IDLE;
                end
                else if (!out_valid_reg || out_ready)
                begin
                    // The result register frees up in the same cycle it is drained.
                    cmd.fin_emit = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.fin_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_emit_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_emit_reg  <= job_emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

[sv/blpp_datapath.sv]
// Datapath: byte parser, number accumulators, power-of-ten scaler, result register.
// Depends on blpp_pkg; driven by commands from blpp_ctrl.
`default_nettype none

module blpp_datapath
    import blpp_pkg::*;
#(
    parameter int MAX_EXPONENT = MAX_EXPONENT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire blpp_in_t   in_item,
    input  wire logic       cfg_valid,
    input  wire logic [4:0] cfg_data,
    input  wire blpp_cmd_t  cmd,
    output blpp_status_t    status,
    output blpp_out_t       out_item
);

    localparam logic [10:0] EXP_MAX = 11'(MAX_EXPONENT);

    // Quotient digit of an 8-bit value below 160 divided by ten.
    function automatic logic [3:0] div10_q(input logic [7:0] v);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (v >= 8'(10 * k))
            begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    logic [4:0]  scale_reg;
    logic [2:0]  phase_reg, phase_next;
    logic        stopped_reg, stopped_next;
    logic [2:0]  nphase_reg;
    logic [63:0] mant_reg;
    logic [4:0]  frac_reg;
    logic [6:0]  exp_reg;
    logic [5:0]  drop_reg;
    logic        nneg_reg, eneg_reg;
    logic [63:0] held_price_reg;
    logic        ovf_seen_reg;

    logic [63:0] sc_m_reg;
    logic [8:0]  sc_net_reg;
    logic        sc_neg_reg, sc_sat_reg;
    logic [3:0]  sc_nib_reg, sc_rem_reg;
    logic [63:0] job_price_reg;
    logic        job_ovf_reg;
    blpp_out_t   out_reg;

    logic [7:0] c;
    logic       fin;
    assign c   = in_item.text_byte;
    assign fin = in_item.final_byte;

    // Number grammar applied to the current byte.
    logic        dig, expch, fits, apply_num;
    logic [3:0]  d;
    logic [63:0] mant_mul;
    logic [10:0] exp_mul;
    logic [2:0]  nb_phase;
    logic [63:0] nb_mant;
    logic [4:0]  nb_frac;
    logic [6:0]  nb_exp;
    logic [5:0]  nb_drop;
    logic        nb_nneg, nb_eneg;
    logic        clear_num, qty_quote, emit_on_close, start_price, start_emit;

    assign dig      = (c >= CH_ZERO) && (c <= CH_NINE);
    assign d        = dig ? 4'(c - CH_ZERO) : 4'd0;
    assign expch    = (c == CH_LOW_E) || (c == CH_UP_E);
    assign fits     = (mant_reg < FIT_LIMIT) || ((mant_reg == FIT_LIMIT) && (d <= 4'd5));
    assign mant_mul = (mant_reg << 3) + (mant_reg << 1) + {60'd0, d};
    assign exp_mul  = ({4'd0, exp_reg} << 3) + ({4'd0, exp_reg} << 1) + {7'd0, d};

    always_comb
    begin
        nb_phase = nphase_reg;
        nb_mant  = mant_reg;
        nb_frac  = frac_reg;
        nb_exp   = exp_reg;
        nb_drop  = drop_reg;
        nb_nneg  = nneg_reg;
        nb_eneg  = eneg_reg;
        // An opening quote starts a fresh number, so a job started on that byte sees zero.
        if (clear_num)
        begin
            nb_phase = NU_LEAD;
            nb_mant  = '0;
            nb_frac  = '0;
            nb_exp   = '0;
            nb_drop  = '0;
            nb_nneg  = 1'b0;
            nb_eneg  = 1'b0;
        end
        else if (apply_num)
        begin
            case (nphase_reg)
                NU_LEAD:
                begin
                    if (c == CH_SPACE || c == CH_TAB)
                    begin
                        nb_phase = NU_LEAD;
                    end
                    else if (c == CH_MINUS)
                    begin
                        nb_nneg  = 1'b1;
                        nb_phase = NU_INT;
                    end
                    else if (c == CH_PLUS)
                    begin
                        nb_phase = NU_INT;
                    end
                    else if (dig)
                    begin
                        if (fits)
                        begin
                            nb_mant = mant_mul;
                        end
                        else if (drop_reg < DROP_CAP)
                        begin
                            nb_drop = drop_reg + 6'd1;
                        end
                        nb_phase = NU_INT;
                    end
                    else if (c == CH_DOT)
                    begin
                        nb_phase = NU_FRAC;
                    end
                    else if (expch)
                    begin
                        nb_phase = NU_ESIGN;
                    end
                    else
                    begin
                        nb_phase = NU_DONE;
                    end
                end
                NU_INT:
                begin
                    if (dig)
                    begin
                        if (fits)
                        begin
                            nb_mant = mant_mul;
                        end
                        else if (drop_reg < DROP_CAP)
                        begin
                            nb_drop = drop_reg + 6'd1;
                        end
                    end
                    else if (c == CH_DOT)
                    begin
                        nb_phase = NU_FRAC;
                    end
                    else if (expch)
                    begin
                        nb_phase = NU_ESIGN;
                    end
                    else
                    begin
                        nb_phase = NU_DONE;
                    end
                end
                NU_FRAC:
                begin
                    if (dig)
                    begin
                        if (frac_reg < FRAC_CAP && fits)
                        begin
                            nb_mant = mant_mul;
                            nb_frac = frac_reg + 5'd1;
                        end
                    end
                    else if (expch)
                    begin
                        nb_phase = NU_ESIGN;
                    end
                    else
                    begin
                        nb_phase = NU_DONE;
                    end
                end
                NU_ESIGN:
                begin
                    if (c == CH_MINUS)
                    begin
                        nb_eneg  = 1'b1;
                        nb_phase = NU_EXP;
                    end
                    else if (c == CH_PLUS)
                    begin
                        nb_phase = NU_EXP;
                    end
                    else if (dig)
                    begin
                        nb_exp   = (exp_mul > EXP_MAX) ? 7'(EXP_MAX) : 7'(exp_mul);
                        nb_phase = NU_EXP;
                    end
                    else
                    begin
                        nb_phase = NU_DONE;
                    end
                end
                NU_EXP:
                begin
                    if (dig)
                    begin
                        nb_exp = (exp_mul > EXP_MAX) ? 7'(EXP_MAX) : 7'(exp_mul);
                    end
                    else
                    begin
                        nb_phase = NU_DONE;
                    end
                end
                default:
                begin
                    nb_phase = NU_DONE;
                end
            endcase
        end
    end

    // Array-level parse step.
    always_comb
    begin
        phase_next    = phase_reg;
        stopped_next  = stopped_reg;
        apply_num     = 1'b0;
        clear_num     = 1'b0;
        qty_quote     = 1'b0;
        emit_on_close = 1'b0;
        start_price   = 1'b0;
        if (!stopped_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (c == CH_LBRACK)
                    begin
                        phase_next = PH_BETWEEN;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                PH_BETWEEN:
                begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF
                        || c == CH_COMMA)
                    begin
                        phase_next = PH_BETWEEN;
                    end
                    else if (c == CH_LBRACK)
                    begin
                        phase_next = PH_SEEK_PQ;
                    end
                    else
                    begin
                        stopped_next = 1'b1;
                    end
                end
                PH_SEEK_PQ:
                begin
                    if (c == CH_QUOTE)
                    begin
                        clear_num  = 1'b1;
                        phase_next = PH_PRICE;
                    end
                end
                PH_PRICE:
                begin
                    if (c == CH_QUOTE)
                    begin
                        start_price = !fin;
                        phase_next  = PH_SEEK_QQ;
                    end
                    else
                    begin
                        apply_num = 1'b1;
                    end
                end
                PH_SEEK_QQ:
                begin
                    if (c == CH_QUOTE)
                    begin
                        clear_num  = 1'b1;
                        phase_next = PH_QTY;
                    end
                end
                PH_QTY:
                begin
                    if (c == CH_QUOTE)
                    begin
                        qty_quote  = 1'b1;
                        phase_next = PH_SEEK_CLOSE;
                    end
                    else
                    begin
                        apply_num = 1'b1;
                    end
                end
                PH_SEEK_CLOSE:
                begin
                    if (c == CH_RBRACK)
                    begin
                        emit_on_close = 1'b1;
                        phase_next    = PH_BETWEEN;
                    end
                end
                default:
                begin
                    stopped_next = 1'b1;
                end
            endcase
        end
    end

    assign start_emit = emit_on_close
        || (fin && !stopped_next && (phase_next == PH_QTY || phase_next == PH_SEEK_CLOSE));

    // Net power of ten for the number as it stands after this byte.
    logic [8:0] net_calc, exp_term;
    assign exp_term = nb_eneg ? (9'd0 - {2'd0, nb_exp}) : {2'd0, nb_exp};
    assign net_calc = {4'd0, scale_reg} - {4'd0, nb_frac} + {3'd0, nb_drop} + exp_term;

    // Scaler: one multiply by ten per cycle, or a divide by ten over 16 nibble steps.
    logic        sc_net_neg, sc_m_zero, sc_div, sc_ovf;
    logic [7:0]  div_v;
    logic [3:0]  div_q, div_r;
    logic [63:0] sc_limit, sc_mag, sc_res;

    assign sc_net_neg = sc_net_reg[8];
    assign sc_m_zero  = (sc_m_reg == 64'd0);
    assign sc_div     = (sc_nib_reg != 4'd0) || (sc_net_neg && !sc_m_zero);
    assign div_v      = {sc_rem_reg, sc_m_reg[63:60]};
    assign div_q      = div10_q(div_v);
    assign div_r      = 4'(div_v - ({4'd0, div_q} << 3) - ({4'd0, div_q} << 1));
    assign sc_limit   = sc_neg_reg ? NEG_LIMIT : POS_LIMIT;
    assign sc_ovf     = sc_sat_reg || (sc_m_reg > sc_limit);
    assign sc_mag     = sc_ovf ? sc_limit : sc_m_reg;
    assign sc_res     = sc_neg_reg ? (64'd0 - sc_mag) : sc_mag;

    assign status.start_price = start_price;
    assign status.start_emit  = start_emit;
    assign status.done        = (sc_nib_reg == 4'd0)
        && (sc_sat_reg || sc_net_reg == 9'd0 || sc_m_zero);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg      <= DECIMAL_SCALE_RESET;
            phase_reg      <= PH_START;
            stopped_reg    <= 1'b0;
            nphase_reg     <= NU_LEAD;
            mant_reg       <= '0;
            frac_reg       <= '0;
            exp_reg        <= '0;
            drop_reg       <= '0;
            nneg_reg       <= 1'b0;
            eneg_reg       <= 1'b0;
            held_price_reg <= '0;
            ovf_seen_reg   <= 1'b0;
            sc_m_reg       <= '0;
            sc_net_reg     <= '0;
            sc_neg_reg     <= 1'b0;
            sc_nib_reg     <= '0;
            sc_rem_reg     <= '0;
            sc_sat_reg     <= 1'b0;
            job_price_reg  <= '0;
            job_ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                scale_reg <= cfg_data;
            end
            if (cmd.take)
            begin
                if (start_price || start_emit)
                begin
                    sc_m_reg   <= nb_mant;
                    sc_net_reg <= net_calc;
                    sc_neg_reg <= nb_nneg;
                    sc_sat_reg <= 1'b0;
                    sc_nib_reg <= '0;
                    sc_rem_reg <= '0;
                end
                if (start_emit)
                begin
                    job_price_reg <= held_price_reg;
                    job_ovf_reg   <= ovf_seen_reg;
                end
                if (fin)
                begin
                    phase_reg      <= PH_START;
                    stopped_reg    <= 1'b0;
                    held_price_reg <= '0;
                    ovf_seen_reg   <= 1'b0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    stopped_reg <= stopped_next;
                end
                if (fin || clear_num)
                begin
                    nphase_reg <= NU_LEAD;
                    mant_reg   <= '0;
                    frac_reg   <= '0;
                    exp_reg    <= '0;
                    drop_reg   <= '0;
                    nneg_reg   <= 1'b0;
                    eneg_reg   <= 1'b0;
                end
                else
                begin
                    nphase_reg <= qty_quote ? NU_DONE : nb_phase;
                    mant_reg   <= nb_mant;
                    frac_reg   <= nb_frac;
                    exp_reg    <= nb_exp;
                    drop_reg   <= nb_drop;
                    nneg_reg   <= nb_nneg;
                    eneg_reg   <= nb_eneg;
                end
            end
            if (cmd.step)
            begin
                if (sc_div)
                begin
                    sc_m_reg   <= {sc_m_reg[59:0], div_q};
                    sc_rem_reg <= (sc_nib_reg == 4'd15) ? 4'd0 : div_r;
                    sc_nib_reg <= sc_nib_reg + 4'd1;
                    if (sc_nib_reg == 4'd15)
                    begin
                        sc_net_reg <= sc_net_reg + 9'd1;
                    end
                end
                else if (sc_m_reg > MUL_LIMIT)
                begin
                    sc_sat_reg <= 1'b1;
                end
                else
                begin
                    sc_m_reg   <= (sc_m_reg << 3) + (sc_m_reg << 1);
                    sc_net_reg <= sc_net_reg - 9'd1;
                end
            end
            if (cmd.fin_price)
            begin
                held_price_reg <= sc_res;
                ovf_seen_reg   <= sc_ovf;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin_emit)
        begin
            out_reg.price_value    <= job_price_reg;
            out_reg.quantity_value <= sc_res;
            out_reg.saturated      <= job_ovf_reg || sc_ovf;
        end
    end

    assign out_item = out_reg;

endmodule

`default_nettype wire

[bench/book_level_pair_parser_core_test.sv]
// Self-checking bench for book_level_pair_parser_core: JSON pair text in, scaled values out.
// Depends on blpp_pkg and the RTL; predicts each result with a scoreboard class.
`default_nettype none

module book_level_pair_parser_core_test;
    import blpp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef byte unsigned text_q_t[$];

    // Tracks the parser state from the accepted bytes and checks each result in order.
    class pair_scoreboard;
        blpp_out_t pending[$];
        int errors;
        int checked;
        logic [4:0] scale;
        logic [2:0] phase;
        logic [2:0] nphase;
        logic [63:0] mant;
        int frac_cnt;
        int exp_acc;
        int dropped;
        bit neg;
        bit eneg;
        logic [63:0] price_held;
        bit price_ovf;
        bit stopped;

        function new();
            errors = 0;
            checked = 0;
            scale = DECIMAL_SCALE_RESET;
            clear_all();
        endfunction

        function void clear_num();
            nphase = NU_LEAD;
            mant = '0;
            frac_cnt = 0;
            exp_acc = 0;
            neg = 0;
            eneg = 0;
            dropped = 0;
        endfunction

        function void clear_all();
            phase = PH_START;
            stopped = 0;
            price_held = '0;
            price_ovf = 0;
            clear_num();
        endfunction

        function bit fits(int d);
            logic [63:0] top;
            top = 64'hFFFF_FFFF_FFFF_FFFF - 64'(d);
            return mant <= top / 10;
        endfunction

        function void take_int(int d);
            if (fits(d))
                mant = mant * 10 + 64'(d);
            else if (dropped < 63)
                dropped++;
        endfunction

        function void take_frac(int d);
            if (frac_cnt < 31 && fits(d))
            begin
                mant = mant * 10 + 64'(d);
                frac_cnt++;
            end
        endfunction

        function void take_exp(int d);
            int e;
            e = exp_acc * 10 + d;
            exp_acc = (e > MAX_EXPONENT_DEF) ? MAX_EXPONENT_DEF : e;
        endfunction

        function void number_char(logic [7:0] c);
            bit dig;
            bit expch;
            int d;
            dig = (c >= CH_ZERO) && (c <= CH_NINE);
            d = dig ? int'(c - CH_ZERO) : 0;
            expch = (c == CH_LOW_E) || (c == CH_UP_E);
            case (nphase)
                NU_LEAD:
                    if (c == CH_SPACE || c == CH_TAB)
                        ;
                    else if (c == CH_MINUS)
                    begin
                        neg = 1;
                        nphase = NU_INT;
                    end
                    else if (c == CH_PLUS) nphase = NU_INT;
                    else if (dig)
                    begin
                        take_int(d);
                        nphase = NU_INT;
                    end
                    else if (c == CH_DOT) nphase = NU_FRAC;
                    else if (expch) nphase = NU_ESIGN;
                    else nphase = NU_DONE;
                NU_INT:
                    if (dig) take_int(d);
                    else if (c == CH_DOT) nphase = NU_FRAC;
                    else if (expch) nphase = NU_ESIGN;
                    else nphase = NU_DONE;
                NU_FRAC:
                    if (dig) take_frac(d);
                    else if (expch) nphase = NU_ESIGN;
                    else nphase = NU_DONE;
                NU_ESIGN:
                    if (c == CH_MINUS)
                    begin
                        eneg = 1;
                        nphase = NU_EXP;
                    end
                    else if (c == CH_PLUS) nphase = NU_EXP;
                    else if (dig)
                    begin
                        take_exp(d);
                        nphase = NU_EXP;
                    end
                    else nphase = NU_DONE;
                NU_EXP:
                    if (dig) take_exp(d);
                    else nphase = NU_DONE;
                default:
                    nphase = NU_DONE;
            endcase
        endfunction

        // Applies the net power of ten with truncation and clamps to the signed range.
        function logic [63:0] scaled(output bit ovf);
            int net;
            logic [63:0] lim;
            logic [63:0] m;
            bit sat;
            net = int'(scale) - frac_cnt + dropped + (eneg ? -exp_acc : exp_acc);
            lim = neg ? NEG_LIMIT : POS_LIMIT;
            m = mant;
            sat = 0;
            while (net < 0 && m != 0)
            begin
                m = m / 10;
                net++;
            end
            while (net > 0 && m != 0)
            begin
                if (m > lim / 10)
                begin
                    sat = 1;
                    break;
                end
                m = m * 10;
                net--;
            end
            ovf = sat || (m > lim);
            if (ovf) m = lim;
            return neg ? (64'd0 - m) : m;
        endfunction

        function void push_result();
            blpp_out_t r;
            bit qo;
            r.quantity_value = scaled(qo);
            r.price_value = price_held;
            r.saturated = price_ovf || qo;
            pending.push_back(r);
        endfunction

        function void note_byte(blpp_in_t it);
            logic [7:0] c;
            bit o;
            c = it.text_byte;
            if (!stopped)
                case (phase)
                    PH_START:
                        if (c == CH_LBRACK) phase = PH_BETWEEN;
                        else stopped = 1;
                    PH_BETWEEN:
                        if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF
                            || c == CH_COMMA)
                            ;
                        else if (c == CH_LBRACK) phase = PH_SEEK_PQ;
                        else stopped = 1;
                    PH_SEEK_PQ:
                        if (c == CH_QUOTE)
                        begin
                            clear_num();
                            phase = PH_PRICE;
                        end
                    PH_PRICE:
                        if (c == CH_QUOTE)
                        begin
                            price_held = scaled(o);
                            price_ovf = o;
                            phase = PH_SEEK_QQ;
                        end
                        else number_char(c);
                    PH_SEEK_QQ:
                        if (c == CH_QUOTE)
                        begin
                            clear_num();
                            phase = PH_QTY;
                        end
                    PH_QTY:
                        if (c == CH_QUOTE)
                        begin
                            nphase = NU_DONE;
                            phase = PH_SEEK_CLOSE;
                        end
                        else number_char(c);
                    PH_SEEK_CLOSE:
                        if (c == CH_RBRACK)
                        begin
                            push_result();
                            phase = PH_BETWEEN;
                        end
                    default:
                        stopped = 1;
                endcase
            if (it.final_byte)
            begin
                // A pair cut short by the last byte still reports once its quantity began.
                if (!stopped && (phase == PH_QTY || phase == PH_SEEK_CLOSE)
                    && !(c == CH_RBRACK && phase == PH_BETWEEN))
                    push_result();
                clear_all();
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
            errors++;
        endtask

        task check_result(blpp_out_t got);
            blpp_out_t want;
            if (pending.size() == 0)
            begin
                report("result with nothing pending", got.price_value, 0);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.price_value !== want.price_value)
                report("price_value", got.price_value, want.price_value);
            if (got.quantity_value !== want.quantity_value)
                report("quantity_value", got.quantity_value, want.quantity_value);
            if (got.saturated !== want.saturated)
                report("saturated", got.saturated, want.saturated);
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    blpp_in_t in_item;
    logic out_valid;
    logic out_ready;
    blpp_out_t out_item;
    logic cfg_valid;
    logic cfg_ready;
    logic [4:0] cfg_data;

    pair_scoreboard book;
    int bytes_sent;
    int hold_request;
    bit sender_steady;
    bit receiver_steady;

    book_level_pair_parser_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("book_level_pair_parser_core: mismatch");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            book.check_result(out_item);

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        int g;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                g = hold_request;
                hold_request = 0;
                out_ready <= 0;
                repeat (g) @(negedge clk);
            end
            else if (receiver_steady)
                out_ready <= 1;
            else
            begin
                g = gap_len();
                if (g > 0)
                begin
                    out_ready <= 0;
                    repeat (g) @(negedge clk);
                end
                out_ready <= 1;
            end
        end
    end

    task send_byte(logic [7:0] c, logic fin);
        int g;
        g = sender_steady ? 0 : gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            in_valid <= 0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1;
        in_item.text_byte <= c;
        in_item.final_byte <= fin;
        do @(posedge clk); while (!in_ready);
        book.note_byte('{text_byte: c, final_byte: fin});
        bytes_sent++;
    endtask

    task send_text(text_q_t t);
        foreach (t[i])
            send_byte(t[i], i == t.size() - 1);
    endtask

    task send_str(string s);
        text_q_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_text(t);
    endtask

    // Lets every pending result drain, then covers the longest scaling job still running.
    task drain();
        @(negedge clk);
        in_valid <= 0;
        while (book.pending.size() != 0) @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    task write_scale(logic [4:0] v);
        drain();
        @(negedge clk);
        cfg_valid <= 1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        book.scale = v;
        @(negedge clk);
        cfg_valid <= 0;
    endtask

    function automatic void add_digits(ref text_q_t t, input int n);
        for (int i = 0; i < n; i++)
            t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_number(ref text_q_t t);
        int r;
        byte unsigned junk;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            t.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        r = $urandom_range(0, 5);
        if (r < 2) t.push_back(CH_MINUS);
        else if (r == 2) t.push_back(CH_PLUS);
        add_digits(t, $urandom_range(0, 9) == 0 ? $urandom_range(7, 25) : $urandom_range(0, 6));
        if ($urandom_range(0, 1))
        begin
            t.push_back(CH_DOT);
            add_digits(t, $urandom_range(0, 9) == 0 ? $urandom_range(9, 40)
                                                     : $urandom_range(0, 8));
        end
        if ($urandom_range(0, 3) == 0)
        begin
            t.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
            r = $urandom_range(0, 2);
            if (r == 0) t.push_back(CH_MINUS);
            else if (r == 1) t.push_back(CH_PLUS);
            add_digits(t, $urandom_range(0, 3));
        end
        if ($urandom_range(0, 9) == 0)
        begin
            junk = 8'($urandom_range(0, 255));
            if (junk != CH_QUOTE) t.push_back(junk);
        end
    endfunction

    // One array: mostly well-formed pairs, sometimes cut short, sometimes plain noise.
    function automatic text_q_t make_array();
        text_q_t t;
        int kind;
        int cut;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 10)) t.push_back(8'($urandom_range(0, 255)));
            return t;
        end
        t.push_back(CH_LBRACK);
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 3) == 0) t.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
            t.push_back(CH_LBRACK);
            t.push_back(CH_QUOTE);
            add_number(t);
            t.push_back(CH_QUOTE);
            t.push_back(CH_COMMA);
            if ($urandom_range(0, 3) == 0) t.push_back(CH_SPACE);
            t.push_back(CH_QUOTE);
            add_number(t);
            t.push_back(CH_QUOTE);
            t.push_back(CH_RBRACK);
            t.push_back(CH_COMMA);
        end
        if (t.size() > 1) void'(t.pop_back());
        t.push_back(CH_RBRACK);
        if (kind == 1 && t.size() > 2)
        begin
            cut = $urandom_range(1, t.size() - 1);
            while (t.size() > cut) void'(t.pop_back());
        end
        else if (kind == 2)
            t.push_back(8'($urandom_range(0, 255)));
        return t;
    endfunction

    initial
    begin
        logic [4:0] scales[6];
        int quota;
        book = new();
        bytes_sent = 0;
        hold_request = 0;
        sender_steady = 0;
        receiver_steady = 0;
        rst_n = 0;
        in_valid = 0;
        in_item = '0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_str("[[\"1.5\",\"20\"],[\"-9223372036854775808\",\"18446744073709551615\"]]");
        send_str("x[[\"1\",\"2\"]]");
        send_str("[[\"\",\"abc\"] ,\t]z[");
        send_str("[[\" \t+.5e+2\",\"1E-99\"],[\"12345678901234567890123\",\"9e999\"]]");
        send_str("[[\"-0\",\".0000000000000000000000000000000000000001\"],[\"1\",\"7");
        send_str("[[\"-1e-5\",\"");

        scales = '{5'd0, 5'd18, 5'd31, 5'd2, 5'd8, 5'd0};
        scales[5] = 5'($urandom_range(0, 31));
        foreach (scales[p])
        begin
            write_scale(scales[p]);
            quota = bytes_sent + 240;
            sender_steady = (p == 3);
            receiver_steady = (p == 4);
            if (p == 2) hold_request = 600;
            while (bytes_sent < quota)
            begin
                send_text(make_array());
                if (p != 3) sender_steady = ($urandom_range(0, 7) == 0);
            end
            if (p == 1) drain();
        end

        drain();
        $display("Sent %0d text bytes over six scale settings; %0d results checked.",
                 bytes_sent, book.checked);
        if (book.errors == 0)
            $display("book_level_pair_parser_core: match");
        else
            $display("book_level_pair_parser_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
